>>> design/iahist_pkg.sv
package iahist_pkg;

	// histogram geometry
	localparam int NUM_BINS   = 1024;
	localparam int ADDR_BITS  = $clog2(NUM_BINS);
	localparam int COUNT_BITS = 32;

	// fixed field widths
	localparam int BIN_W       = 10;
	localparam int COUNT_W     = 32;
	localparam int SEC_BITS    = 32;
	localparam int MICRO_BITS  = 20;
	localparam int BUCKET_BITS = 20;

	// seconds * 1e6 + micros always fits in 52 bits
	localparam int TIME_BITS     = 52;
	// ceiling numerator: gap below one second plus bucket size minus one
	localparam int DIV_BITS      = 21;
	localparam int DIV_STEP_BITS = $clog2(DIV_BITS + 1);

	localparam logic [MICRO_BITS-1:0] USEC_PER_SEC = 20'd1000000;

	// header constants
	localparam logic [7:0] PROTO_TCP     = 8'd6;
	localparam logic [7:0] FLAG_SYN_ONLY = 8'h02;
	localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
	localparam logic [3:0] VER_IPV4      = 4'd4;
	localparam logic [3:0] VER_IPV6      = 4'd6;

	typedef enum logic [3:0] {
		ST_RECORDED    = 4'd0,
		ST_FIRST       = 4'd1,
		ST_BAD_IP_LEN  = 4'd2,
		ST_NOT_TCP     = 4'd3,
		ST_V6_IGNORED  = 4'd4,
		ST_BAD_VERSION = 4'd5,
		ST_BAD_TCP_LEN = 4'd6,
		ST_NOT_SYN     = 4'd7,
		ST_BACKWARDS   = 4'd8,
		ST_READ        = 4'd9
	} status_t;

	typedef enum logic [3:0] {
		CTL_CLEAR,
		CTL_IDLE,
		CTL_MUL,
		CTL_ADD,
		CTL_CMP,
		CTL_GAP,
		CTL_DIV,
		CTL_LOOKUP,
		CTL_UPDATE,
		CTL_DONE
	} ctl_state_t;

	typedef struct packed {
		logic                   start;
		logic [DIV_BITS-1:0]    num;
		logic [BUCKET_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_BITS-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic                 valid;
		logic                 incr;
		logic [ADDR_BITS-1:0] addr;
	} store_req_t;

	typedef struct packed {
		logic                  ready;
		logic                  done;
		logic [COUNT_BITS-1:0] count;
	} store_rsp_t;

endpackage

>>> design/syn_interarrival_histogram_core.sv
// SYN interarrival histogram.
// Input channel (in_valid / in_stall) carries one item: a packet arrival
// (kind 0) with pre-extracted header bytes and a capture timestamp, or a
// read of one histogram bin (kind 1). Each item yields exactly one result on
// the output channel (out_valid / out_stall): status, bin and bin_count.
// Items are worked on one at a time. A rejected packet goes straight to its
// result; a first arrival or backwards timestamp passes multiply, add and
// compare; an in-range read does the memory lookup and update; a recorded
// SYN does all of these and the 21-step bit-serial divider that forms the
// ceiling of gap over bucket size, which a one-second-or-more gap skips.
// The result goes valid in the same cycle as the next item can be taken.
// The histogram memory has one read and one write port; an entry is read,
// then incremented and written back. After reset it is swept to zero, one
// bin per cycle; in_stall stays high until the controller has left CTL_CLEAR.
// Configuration writes (cfg_wen, cfg_index, cfg_data) are taken at any time
// and are meant for when the block is idle. A result waits in the output
// register while out_stall is high; the next item may still be accepted and
// worked on, and its result is held back until the output register frees.
module syn_interarrival_histogram_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic                                 cfg_index,
	input  logic [iahist_pkg::BUCKET_BITS-1:0]   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 kind,
	input  logic [7:0]                           ip_first_byte,
	input  logic [7:0]                           ip_protocol,
	input  logic [7:0]                           tcp_offset_byte,
	input  logic [7:0]                           tcp_flag_bits,
	input  logic [iahist_pkg::SEC_BITS-1:0]      stamp_seconds,
	input  logic [iahist_pkg::MICRO_BITS-1:0]    stamp_micros,
	input  logic [iahist_pkg::BIN_W-1:0]         read_bin,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [3:0]                           status,
	output logic [iahist_pkg::BIN_W-1:0]         bin,
	output logic [iahist_pkg::COUNT_W-1:0]       bin_count
);
	import iahist_pkg::*;

	localparam logic REG_BUCKET_SIZE = 1'b0;
	localparam logic REG_COUNT_IPV6  = 1'b1;

	ctl_state_t state_q, state_d;

	logic [BUCKET_BITS-1:0] bucket_q;
	logic                   v6_en_q;
	logic                   have_last_q;
	logic [TIME_BITS-1:0]   last_q;

	logic [SEC_BITS-1:0]   secs_q;
	logic [MICRO_BITS-1:0] usec_q;
	logic [TIME_BITS-1:0]  mul_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [TIME_BITS-1:0]  gap_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic                  incr_q;

	logic [3:0]         res_st_q;
	logic [BIN_W-1:0]   res_bin_q;
	logic [COUNT_W-1:0] res_cnt_q;

	logic               out_valid_q;
	logic [3:0]         out_st_q;
	logic [BIN_W-1:0]   out_bin_q;
	logic [COUNT_W-1:0] out_cnt_q;

	status_t                hdr_st;
	logic                   accept;
	logic                   read_out;
	logic [TIME_BITS:0]     diff;
	logic                   long_gap;
	logic [BUCKET_BITS-1:0] bucket_eff;
	logic                   out_load;

	div_req_t   div_req;
	div_rsp_t   div_rsp;
	store_req_t store_req;
	store_rsp_t store_rsp;

	// header checks on the incoming item
	always_comb begin
		hdr_st = ST_RECORDED;
		if (ip_first_byte[7:4] == VER_IPV4) begin
			if (ip_first_byte[3:0] < MIN_HDR_WORDS)
				hdr_st = ST_BAD_IP_LEN;
			else if (ip_protocol != PROTO_TCP)
				hdr_st = ST_NOT_TCP;
		end else if (ip_first_byte[7:4] == VER_IPV6) begin
			if (!v6_en_q)
				hdr_st = ST_V6_IGNORED;
			else if (ip_protocol != PROTO_TCP)
				hdr_st = ST_NOT_TCP;
		end else begin
			hdr_st = ST_BAD_VERSION;
		end
		if (hdr_st == ST_RECORDED) begin
			if (tcp_offset_byte[7:4] < MIN_HDR_WORDS)
				hdr_st = ST_BAD_TCP_LEN;
			else if (tcp_flag_bits != FLAG_SYN_ONLY)
				hdr_st = ST_NOT_SYN;
		end
	end

	// gap arithmetic helpers, read range check and output load condition
	always_comb begin
		read_out   = (32'(read_bin) >= NUM_BINS);
		diff       = {1'b0, now_q} - {1'b0, last_q};
		long_gap   = (gap_q >= TIME_BITS'(USEC_PER_SEC));
		bucket_eff = (bucket_q == '0) ? BUCKET_BITS'(1) : bucket_q;
		out_load   = (state_q == CTL_DONE) && (!out_valid_q || !out_stall);
	end

	// next state and unit requests
	always_comb begin
		state_d         = state_q;
		accept          = 1'b0;
		div_req.start   = 1'b0;
		div_req.num     = DIV_BITS'(gap_q[MICRO_BITS-1:0]) + DIV_BITS'(bucket_eff)
		                  - DIV_BITS'(1);
		div_req.den     = bucket_eff;
		store_req.valid = 1'b0;
		store_req.incr  = incr_q;
		store_req.addr  = addr_q;
		case (state_q)
			CTL_CLEAR: begin
				if (store_rsp.ready)
					state_d = CTL_IDLE;
			end
			CTL_IDLE: begin
				if (in_valid) begin
					accept = 1'b1;
					if (kind)
						state_d = read_out ? CTL_DONE : CTL_LOOKUP;
					else if (hdr_st != ST_RECORDED)
						state_d = CTL_DONE;
					else
						state_d = CTL_MUL;
				end
			end
			CTL_MUL: state_d = CTL_ADD;
			CTL_ADD: state_d = CTL_CMP;
			CTL_CMP: begin
				if (!have_last_q || diff[TIME_BITS])
					state_d = CTL_DONE;
				else
					state_d = CTL_GAP;
			end
			CTL_GAP: begin
				if (long_gap) begin
					state_d = CTL_LOOKUP;
				end else begin
					div_req.start = 1'b1;
					state_d       = CTL_DIV;
				end
			end
			CTL_DIV: begin
				if (div_rsp.done)
					state_d = CTL_LOOKUP;
			end
			CTL_LOOKUP: begin
				store_req.valid = 1'b1;
				state_d         = CTL_UPDATE;
			end
			CTL_UPDATE: begin
				if (store_rsp.done)
					state_d = CTL_DONE;
			end
			CTL_DONE: begin
				if (out_load)
					state_d = CTL_IDLE;
			end
			default: state_d = CTL_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= CTL_CLEAR;
		else
			state_q <= state_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_q <= BUCKET_BITS'(1);
			v6_en_q  <= 1'b1;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_BUCKET_SIZE: bucket_q <= cfg_data;
				REG_COUNT_IPV6:  v6_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// last arrival: store on first or recorded SYN, forget on backwards time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_last_q <= 1'b0;
			last_q      <= '0;
		end else if (state_q == CTL_CMP) begin
			if (!have_last_q) begin
				have_last_q <= 1'b1;
				last_q      <= now_q;
			end else if (diff[TIME_BITS]) begin
				have_last_q <= 1'b0;
				last_q      <= '0;
			end else begin
				last_q <= now_q;
			end
		end
	end

	// item datapath and result staging
	always_ff @(posedge clk) begin
		case (state_q)
			CTL_IDLE: begin
				if (accept) begin
					secs_q    <= stamp_seconds;
					usec_q    <= stamp_micros;
					addr_q    <= ADDR_BITS'(read_bin);
					incr_q    <= !kind;
					res_cnt_q <= '0;
					if (kind) begin
						res_st_q  <= ST_READ;
						res_bin_q <= read_bin;
					end else begin
						res_st_q  <= hdr_st;
						res_bin_q <= '0;
					end
				end
			end
			CTL_MUL: mul_q <= TIME_BITS'(secs_q) * TIME_BITS'(USEC_PER_SEC);
			CTL_ADD: now_q <= mul_q + TIME_BITS'(usec_q);
			CTL_CMP: begin
				gap_q <= diff[TIME_BITS-1:0];
				if (!have_last_q)
					res_st_q <= ST_FIRST;
				else if (diff[TIME_BITS])
					res_st_q <= ST_BACKWARDS;
			end
			CTL_GAP: begin
				if (long_gap)
					addr_q <= ADDR_BITS'(NUM_BINS - 1);
			end
			CTL_DIV: begin
				if (div_rsp.done) begin
					if (div_rsp.quot >= DIV_BITS'(NUM_BINS))
						addr_q <= ADDR_BITS'(NUM_BINS - 1);
					else
						addr_q <= div_rsp.quot[ADDR_BITS-1:0];
				end
			end
			CTL_UPDATE: begin
				if (store_rsp.done) begin
					res_bin_q <= BIN_W'(addr_q);
					res_cnt_q <= COUNT_W'(store_rsp.count);
				end
			end
			default: ;
		endcase
	end

	// output register: hold the result while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_st_q  <= res_st_q;
			out_bin_q <= res_bin_q;
			out_cnt_q <= res_cnt_q;
		end
	end

	iahist_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	iahist_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rsp    (store_rsp)
	);

	assign in_stall  = (state_q != CTL_IDLE);
	assign out_valid = out_valid_q;
	assign status    = out_st_q;
	assign bin       = out_bin_q;
	assign bin_count = out_cnt_q;

endmodule

>>> design/iahist_div.sv
module iahist_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iahist_pkg::div_req_t req,
	output iahist_pkg::div_rsp_t rsp
);
	import iahist_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic [DIV_STEP_BITS-1:0] step_q;
	logic [DIV_BITS-1:0]      num_q;
	logic [DIV_BITS-1:0]      rem_q;
	logic [DIV_BITS-1:0]      quot_q;
	logic [BUCKET_BITS-1:0]   den_q;

	logic [DIV_BITS-1:0] rem_shift;
	logic [DIV_BITS:0]   trial;
	logic                fits;

	// one restoring step: bring down the next numerator bit, try the subtract
	always_comb begin
		rem_shift = {rem_q[DIV_BITS-2:0], num_q[DIV_BITS-1]};
		trial     = {1'b0, rem_shift} - {{(DIV_BITS + 1 - BUCKET_BITS){1'b0}}, den_q};
		fits      = !trial[DIV_BITS];
	end

	// sequence the steps, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + DIV_STEP_BITS'(1);
				if (step_q == DIV_STEP_BITS'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[DIV_BITS-2:0], 1'b0};
			rem_q  <= fits ? trial[DIV_BITS-1:0] : rem_shift;
			quot_q <= {quot_q[DIV_BITS-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

>>> design/iahist_store.sv
module iahist_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  iahist_pkg::store_req_t req,
	output iahist_pkg::store_rsp_t rsp
);
	import iahist_pkg::*;

	logic [COUNT_BITS-1:0] mem [NUM_BINS];

	logic                  clearing_q;
	logic [ADDR_BITS-1:0]  clr_addr_q;
	logic                  valid_s1;
	logic                  incr_s1;
	logic [ADDR_BITS-1:0]  addr_s1;
	logic [COUNT_BITS-1:0] rd_data_s1;

	logic                  wr_en;
	logic [ADDR_BITS-1:0]  wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic [COUNT_BITS-1:0] next_count;

	// saturating increment of the entry read last cycle; clear sweep takes the port first
	always_comb begin
		next_count = (rd_data_s1 == '1) ? rd_data_s1 : rd_data_s1 + COUNT_BITS'(1);
		wr_en      = clearing_q || (valid_s1 && incr_s1);
		wr_addr    = clearing_q ? clr_addr_q : addr_s1;
		wr_data    = clearing_q ? '0 : next_count;
	end

	// clear sweep after reset and request tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			valid_s1 <= req.valid && !clearing_q;
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
				if (clr_addr_q == ADDR_BITS'(NUM_BINS - 1))
					clearing_q <= 1'b0;
			end
		end
	end

	// memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (req.valid) begin
			rd_data_s1 <= mem[req.addr];
			incr_s1    <= req.incr;
			addr_s1    <= req.addr;
		end
	end

	assign rsp.ready = !clearing_q;
	assign rsp.done  = valid_s1;
	assign rsp.count = incr_s1 ? next_count : rd_data_s1;

endmodule

>>> dv/iahist_tb_pkg.sv
package iahist_tb_pkg;

	// configuration register indexes
	typedef enum logic {
		REG_BUCKET_SIZE = 1'b0,
		REG_COUNT_IPV6  = 1'b1
	} reg_index_t;

	// item kinds on the input channel
	typedef enum logic {
		KIND_PACKET = 1'b0,
		KIND_READ   = 1'b1
	} item_kind_t;

endpackage

>>> dv/syn_interarrival_histogram_checker.sv
module syn_interarrival_histogram_checker
	import iahist_pkg::*;
	import iahist_tb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic                   cfg_index,
	input  logic [BUCKET_BITS-1:0] cfg_data,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   kind,
	input  logic [7:0]             ip_first_byte,
	input  logic [7:0]             ip_protocol,
	input  logic [7:0]             tcp_offset_byte,
	input  logic [7:0]             tcp_flag_bits,
	input  logic [SEC_BITS-1:0]    stamp_seconds,
	input  logic [MICRO_BITS-1:0]  stamp_micros,
	input  logic [BIN_W-1:0]       read_bin,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [3:0]             status,
	input  logic [BIN_W-1:0]       bin,
	input  logic [COUNT_W-1:0]     bin_count,
	output int                     reports_due,
	output int                     mismatches,
	output int                     reports_seen,
	output int                     recorded_seen
);

	localparam longint unsigned SEC_US = 64'(USEC_PER_SEC);

	typedef struct packed {
		status_t            st;
		logic [BIN_W-1:0]   bin;
		logic [COUNT_W-1:0] count;
	} bin_report_t;

	// shadow of the histogram and the arrival tracker
	logic [COUNT_BITS-1:0]  counts [NUM_BINS];
	logic [SEC_BITS-1:0]    prev_sec;
	logic [MICRO_BITS-1:0]  prev_us;
	logic                   prev_valid;
	logic [BUCKET_BITS-1:0] width_us;
	logic                   v6_on;

	bin_report_t reports [$];
	int fail_total;
	int seen_total;
	int rec_total;

	// header screening, first failing check wins
	function automatic status_t header_verdict(logic [7:0] first, logic [7:0] proto,
			logic [7:0] tcp_off, logic [7:0] flags);
		if (first[7:4] == VER_IPV4) begin
			if (first[3:0] < MIN_HDR_WORDS)
				return ST_BAD_IP_LEN;
			if (proto != PROTO_TCP)
				return ST_NOT_TCP;
		end else if (first[7:4] == VER_IPV6) begin
			if (!v6_on)
				return ST_V6_IGNORED;
			if (proto != PROTO_TCP)
				return ST_NOT_TCP;
		end else begin
			return ST_BAD_VERSION;
		end
		if (tcp_off[7:4] < MIN_HDR_WORDS)
			return ST_BAD_TCP_LEN;
		if (flags != FLAG_SYN_ONLY)
			return ST_NOT_SYN;
		return ST_RECORDED;
	endfunction

	// work out the report for the item on the input port and update the shadow
	function automatic bin_report_t score_item();
		bin_report_t rep;
		longint unsigned now_us;
		longint unsigned then_us;
		longint unsigned gap_us;
		longint unsigned step_us;
		longint unsigned slot;
		rep = '{st: ST_RECORDED, bin: '0, count: '0};
		if (kind == KIND_READ) begin
			rep.st = ST_READ;
			rep.bin = read_bin;
			rep.count = counts[read_bin];
			return rep;
		end
		rep.st = header_verdict(ip_first_byte, ip_protocol, tcp_offset_byte, tcp_flag_bits);
		if (rep.st != ST_RECORDED)
			return rep;
		if (!prev_valid) begin
			prev_sec = stamp_seconds;
			prev_us = stamp_micros;
			prev_valid = 1'b1;
			rep.st = ST_FIRST;
			return rep;
		end
		now_us = 64'(stamp_seconds) * SEC_US + 64'(stamp_micros);
		then_us = 64'(prev_sec) * SEC_US + 64'(prev_us);
		if (now_us < then_us) begin
			prev_valid = 1'b0;
			prev_sec = '0;
			prev_us = '0;
			rep.st = ST_BACKWARDS;
			return rep;
		end
		gap_us = now_us - then_us;
		if (gap_us >= SEC_US) begin
			slot = NUM_BINS - 1;
		end else begin
			step_us = (width_us == '0) ? 64'd1 : 64'(width_us);
			slot = (gap_us + step_us - 1) / step_us;
			if (slot >= NUM_BINS)
				slot = NUM_BINS - 1;
		end
		if (counts[slot] != '1)
			counts[slot] = counts[slot] + 1'b1;
		prev_sec = stamp_seconds;
		prev_us = stamp_micros;
		rep.bin = slot[BIN_W-1:0];
		rep.count = counts[slot];
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		bin_report_t due;
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++)
				counts[i] = '0;
			prev_sec = '0;
			prev_us = '0;
			prev_valid = 1'b0;
			width_us = BUCKET_BITS'(1);
			v6_on = 1'b1;
			reports.delete();
			fail_total = 0;
			seen_total = 0;
			rec_total = 0;
		end else begin
			// retire the oldest report against what the block hands out
			if (out_valid && !out_stall) begin
				seen_total++;
				if (reports.size() == 0) begin
					if (fail_total < 10)
						$display("unexpected report: status %0d bin %0d count %0d",
							status, bin, bin_count);
					fail_total++;
				end else begin
					due = reports.pop_front();
					if (status !== due.st || bin !== due.bin || bin_count !== due.count) begin
						if (fail_total < 10)
							$display("report %0d wrong: status %0d/%0d bin %0d/%0d count %0d/%0d",
								seen_total, due.st, status, due.bin, bin,
								due.count, bin_count);
						fail_total++;
					end
					if (due.st == ST_RECORDED)
						rec_total++;
				end
			end
			// follow register writes
			if (cfg_wen) begin
				if (cfg_index == REG_BUCKET_SIZE)
					width_us = cfg_data;
				else if (cfg_index == REG_COUNT_IPV6)
					v6_on = cfg_data[0];
			end
			// predict each accepted item
			if (in_valid && !in_stall)
				reports.push_back(score_item());
		end
		reports_due <= reports.size();
		mismatches <= fail_total;
		reports_seen <= seen_total;
		recorded_seen <= rec_total;
	end

endmodule

>>> dv/syn_interarrival_histogram_core_tb.sv
module syn_interarrival_histogram_core_tb;
	import iahist_pkg::*;
	import iahist_tb_pkg::*;

	localparam longint unsigned SEC_US = 64'(USEC_PER_SEC);
	localparam longint unsigned MAX_STAMP = 64'hFFFF_FFFF * SEC_US + 64'd999999;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 240;
	localparam int SETTLE_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic                  kind;
		logic [7:0]            first;
		logic [7:0]            proto;
		logic [7:0]            tcp_off;
		logic [7:0]            flags;
		logic [SEC_BITS-1:0]   sec;
		logic [MICRO_BITS-1:0] us;
		logic [BIN_W-1:0]      rbin;
	} arrival_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wen = 1'b0;
	logic                   cfg_index = 1'b0;
	logic [BUCKET_BITS-1:0] cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   kind = 1'b0;
	logic [7:0]             ip_first_byte = '0;
	logic [7:0]             ip_protocol = '0;
	logic [7:0]             tcp_offset_byte = '0;
	logic [7:0]             tcp_flag_bits = '0;
	logic [SEC_BITS-1:0]    stamp_seconds = '0;
	logic [MICRO_BITS-1:0]  stamp_micros = '0;
	logic [BIN_W-1:0]       read_bin = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [3:0]             status;
	logic [BIN_W-1:0]       bin;
	logic [COUNT_W-1:0]     bin_count;

	int reports_due;
	int mismatches;
	int reports_seen;
	int recorded_seen;

	int sender_idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int settings_used = 0;
	int unsigned cycle_count = 0;
	longint unsigned stamp_now = 0;
	logic [BUCKET_BITS-1:0] bucket_now = BUCKET_BITS'(1);

	syn_interarrival_histogram_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.ip_first_byte   (ip_first_byte),
		.ip_protocol     (ip_protocol),
		.tcp_offset_byte (tcp_offset_byte),
		.tcp_flag_bits   (tcp_flag_bits),
		.stamp_seconds   (stamp_seconds),
		.stamp_micros    (stamp_micros),
		.read_bin        (read_bin),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.bin             (bin),
		.bin_count       (bin_count)
	);

	syn_interarrival_histogram_checker hist_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.ip_first_byte   (ip_first_byte),
		.ip_protocol     (ip_protocol),
		.tcp_offset_byte (tcp_offset_byte),
		.tcp_flag_bits   (tcp_flag_bits),
		.stamp_seconds   (stamp_seconds),
		.stamp_micros    (stamp_micros),
		.read_bin        (read_bin),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.bin             (bin),
		.bin_count       (bin_count),
		.reports_due     (reports_due),
		.mismatches      (mismatches),
		.reports_seen    (reports_seen),
		.recorded_seen   (recorded_seen)
	);

	always #10 clk = ~clk;

	// back-pressure on the result channel
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("syn_interarrival_histogram_core regression: fail");
			$finish;
		end
	end

	// well-formed pure SYN with random header lengths
	function automatic arrival_t syn_pkt(logic [SEC_BITS-1:0] sec, logic [MICRO_BITS-1:0] us,
			bit v6);
		arrival_t a;
		a.kind = KIND_PACKET;
		a.first = v6 ? {VER_IPV6, 4'($urandom)} : {VER_IPV4, 4'($urandom_range(5, 15))};
		a.proto = PROTO_TCP;
		a.tcp_off = {4'($urandom_range(5, 15)), 4'($urandom)};
		a.flags = FLAG_SYN_ONLY;
		a.sec = sec;
		a.us = us;
		a.rbin = BIN_W'($urandom);
		return a;
	endfunction

	// SYN at a microsecond time, now and then with micros carried past a second
	function automatic arrival_t syn_after(longint unsigned t, bit v6);
		logic [SEC_BITS-1:0] sec;
		logic [MICRO_BITS-1:0] us;
		sec = SEC_BITS'(t / SEC_US);
		us = MICRO_BITS'(t % SEC_US);
		if ($urandom_range(19) == 0 && sec != '0 && us < MICRO_BITS'(48576)) begin
			sec = sec - 1'b1;
			us = us + USEC_PER_SEC;
		end
		return syn_pkt(sec, us, v6);
	endfunction

	function automatic arrival_t read_req(logic [BIN_W-1:0] b);
		arrival_t a;
		a = arrival_t'({$urandom, $urandom, $urandom, $urandom});
		a.kind = KIND_READ;
		a.rbin = b;
		return a;
	endfunction

	// pick the next random item: mostly SYN trains, some reads, some noise
	function automatic arrival_t next_arrival();
		arrival_t a;
		int pick;
		int shape;
		longint unsigned gap;
		longint unsigned step;
		longint unsigned back;
		pick = $urandom_range(99);
		shape = $urandom_range(99);
		step = (bucket_now == '0) ? 64'd1 : 64'(bucket_now);
		if (pick < 70) begin
			if (shape < 65) begin
				gap = 64'($urandom_range(0, (shape < 45) ? 40 : 1030)) * step;
				case ($urandom_range(2))
					0: if (gap != 0) gap = gap - 1;
					2: gap = gap + 1;
					default: ;
				endcase
			end else if (shape < 80) begin
				gap = 64'($urandom_range(0, 999999));
			end else if (shape < 92) begin
				gap = SEC_US + 64'($urandom_range(0, 5));
			end else begin
				gap = 64'($urandom) * SEC_US + 64'($urandom_range(0, 999999));
			end
			if (stamp_now > MAX_STAMP - gap)
				stamp_now = 64'($urandom_range(0, 1000)) * SEC_US;
			else
				stamp_now = stamp_now + gap;
			return syn_after(stamp_now, 1'($urandom));
		end
		if (pick < 78) begin
			back = 64'($urandom_range(1, 3000000));
			stamp_now = (stamp_now >= back) ? stamp_now - back : 64'd0;
			return syn_after(stamp_now, 1'($urandom));
		end
		if (pick < 88) begin
			if (shape < 50)
				return read_req(BIN_W'($urandom_range(0, 40)));
			if (shape < 65)
				return read_req(BIN_W'(NUM_BINS - 1));
			return read_req(BIN_W'($urandom));
		end
		// noise: a fully random packet or a SYN with one field broken
		if (shape < 50) begin
			a = arrival_t'({$urandom, $urandom, $urandom, $urandom});
			a.kind = KIND_PACKET;
			return a;
		end
		a = syn_after(stamp_now, 1'($urandom));
		case ($urandom_range(4))
			0: a.first = {VER_IPV4, 4'($urandom_range(0, 4))};
			1: do a.proto = 8'($urandom); while (a.proto == PROTO_TCP);
			2: do a.first[7:4] = 4'($urandom);
				while (a.first[7:4] == VER_IPV4 || a.first[7:4] == VER_IPV6);
			3: a.tcp_off[7:4] = 4'($urandom_range(0, 4));
			default: do a.flags = 8'($urandom); while (a.flags == FLAG_SYN_ONLY);
		endcase
		return a;
	endfunction

	// present one item and hold it until taken
	task automatic offer(input arrival_t a);
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		kind <= a.kind;
		ip_first_byte <= a.first;
		ip_protocol <= a.proto;
		tcp_offset_byte <= a.tcp_off;
		tcp_flag_bits <= a.flags;
		stamp_seconds <= a.sec;
		stamp_micros <= a.us;
		read_bin <= a.rbin;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// drop valid and wait for every report to come back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (reports_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers back to back; upper bits of the flag word are junk
	task automatic write_regs(input logic [BUCKET_BITS-1:0] width, input logic v6);
		cfg_wen <= 1'b1;
		cfg_index <= REG_BUCKET_SIZE;
		cfg_data <= width;
		@(posedge clk);
		cfg_index <= REG_COUNT_IPV6;
		cfg_data <= {(BUCKET_BITS-1)'($urandom), v6};
		@(posedge clk);
		cfg_wen <= 1'b0;
		bucket_now = width;
		settings_used++;
	endtask

	task automatic directed_pass();
		arrival_t a;
		// empty bins at both ends
		offer(read_req('0));
		offer(read_req(BIN_W'(NUM_BINS - 1)));
		// each header rejection but IPv6 ignored
		a = syn_pkt('0, '0, 1'b0); a.first = {VER_IPV4, 4'd4}; offer(a);
		a = syn_pkt('0, '0, 1'b0); a.proto = 8'd17; offer(a);
		a = syn_pkt('0, '0, 1'b1); a.proto = 8'hFF; offer(a);
		a = syn_pkt('0, '0, 1'b0); a.first = 8'h00; offer(a);
		a = syn_pkt('0, '0, 1'b0); a.first = 8'hFF; offer(a);
		a = syn_pkt('0, '0, 1'b0); a.tcp_off = 8'h4F; offer(a);
		a = syn_pkt('0, '0, 1'b0); a.flags = 8'h12; offer(a);
		a = syn_pkt('0, '0, 1'b0); a.flags = 8'hFF; offer(a);
		a = syn_pkt('0, '0, 1'b0); a.flags = 8'h00; offer(a);
		// first arrival, zero gap, then both ends of the bin range
		a = syn_pkt('0, '0, 1'b0); a.first = 8'h45; a.tcp_off = 8'h50; offer(a);
		a = syn_pkt('0, '0, 1'b1); a.first = 8'h60; offer(a);
		offer(syn_pkt('0, MICRO_BITS'(1), 1'b0));
		offer(syn_pkt('0, MICRO_BITS'(1024), 1'b1));
		a = syn_pkt('0, MICRO_BITS'(2048), 1'b0); a.first = 8'h4F; a.tcp_off = 8'hF0; offer(a);
		// long gaps, micros past a second, time running backwards
		offer(syn_pkt(SEC_BITS'(1), MICRO_BITS'(2048), 1'b0));
		offer(syn_pkt(SEC_BITS'(1), '1, 1'b1));
		offer(syn_pkt(SEC_BITS'(2), '0, 1'b0));
		offer(syn_pkt('1, MICRO_BITS'(999999), 1'b0));
		offer(syn_pkt('1, '1, 1'b1));
		offer(read_req(BIN_W'(NUM_BINS - 1)));
		offer(read_req('0));
		offer(read_req(BIN_W'(1)));
		// zero bucket width and IPv6 switched off
		settle();
		write_regs('0, 1'b0);
		offer(syn_pkt('1, '1, 1'b1));
		offer(syn_pkt('0, '0, 1'b0));
		offer(syn_pkt('0, '0, 1'b0));
		offer(syn_pkt('0, MICRO_BITS'(7), 1'b0));
	endtask

	initial begin
		logic [BUCKET_BITS-1:0] width;
		logic v6;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		directed_pass();

		// random phases, each with its own settings and idling pattern
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin width = BUCKET_BITS'(1); v6 = 1'b0; end
				1: begin width = BUCKET_BITS'(1000000); v6 = 1'b1; end
				2: begin width = '0; v6 = 1'b1; end
				3: begin width = '1; v6 = 1'b0; end
				4: begin width = BUCKET_BITS'(3); v6 = 1'b1; end
				5: begin width = BUCKET_BITS'($urandom_range(1, 1000)); v6 = 1'b1; end
				6: begin width = BUCKET_BITS'($urandom_range(1, 1000000)); v6 = 1'b0; end
				default: begin width = BUCKET_BITS'(977); v6 = 1'b1; end
			endcase
			write_regs(width, v6);
			case (p % 4)
				0: begin sender_idle_pct = 0; stall_pct = 0; end
				1: begin sender_idle_pct = 83; stall_pct = 0; end
				2: begin sender_idle_pct = 0; stall_pct = 83; end
				default: begin sender_idle_pct = 21; stall_pct = 21; end
			endcase
			stamp_now = 64'($urandom) * SEC_US + 64'($urandom_range(0, 999999));
			repeat (ITEMS_PER_PHASE)
				offer(next_arrival());
		end

		settle();
		$display("covered %0d items over %0d register settings and four idling patterns",
			items_sent, settings_used);
		$display("%0d reports checked, %0d of them recorded interarrival bins",
			reports_seen, recorded_seen);
		if (mismatches == 0)
			$display("syn_interarrival_histogram_core regression: pass");
		else
			$display("syn_interarrival_histogram_core regression: fail");
		$finish;
	end

endmodule
